### src/h2r_pkg.sv
package h2r_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int HUE_BITS     = 16;

    localparam logic [CHANNEL_BITS-1:0] CMAX = {CHANNEL_BITS{1'b1}};
    localparam logic [HUE_BITS:0]       FULL = {1'b1, {HUE_BITS{1'b0}}};
    localparam logic [HUE_BITS:0]       HALF = {2'b01, {(HUE_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_CONVERT    = 2'd0,
        KIND_COMPLEMENT = 2'd1,
        KIND_TINT       = 2'd2,
        KIND_SHADE      = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [HUE_BITS:0]       hue_in;
        logic [CHANNEL_BITS-1:0] saturation_in;
        logic [CHANNEL_BITS-1:0] value_in;
        logic [CHANNEL_BITS-1:0] alpha_in;
        logic [CHANNEL_BITS-1:0] amount;
    } t_hsv_req;

    typedef struct packed {
        logic [HUE_BITS:0]       hue_out;
        logic [CHANNEL_BITS-1:0] saturation_out;
        logic [CHANNEL_BITS-1:0] value_out;
        logic [CHANNEL_BITS-1:0] alpha_out;
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } t_rgb_rsp;

    typedef struct packed {
        logic [HUE_BITS:0]       hue;
        logic [CHANNEL_BITS-1:0] sat;
        logic [CHANNEL_BITS-1:0] val;
        logic [CHANNEL_BITS-1:0] alpha;
    } t_hsva;

endpackage

### src/hsv_to_rgb_converter_unit.sv
// HSV to RGB converter with an optional complement, tint or shade edit.
// Throughput is one request per cycle; each stage holds only while its
// successor is full and stalled, so bubbles collapse under back pressure.
// The synchronous active-low reset clears all stage valid bits; data
// registers are not reset.
module hsv_to_rgb_converter_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  h2r_pkg::t_hsv_req i_req,
    output logic              o_valid,
    input  logic              i_stall,
    output h2r_pkg::t_rgb_rsp o_rsp
);
    import h2r_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int HB = HUE_BITS;

    localparam logic [CB+2:0] TWO_CMAX  = {2'b00, CMAX, 1'b0};
    localparam logic [CB+2:0] FOUR_CMAX = {1'b0, CMAX, 2'b00};

    logic en1, en2, en3, en4, en5;

    // Stage 1: HSV edit.
    logic  r1_valid;
    t_hsva r1_d;
    t_hsva n1_d;

    // Stage 2: v*s product and 6*hue.
    logic            r2_valid;
    t_hsva           r2_d;
    logic [2*CB-1:0] r2_vs;
    logic [HB+2:0]   r2_h6;

    // Stage 3: rounded chroma, offset, sector and fraction.
    logic          r3_valid;
    t_hsva         r3_d;
    logic [CB-1:0] r3_c;
    logic [CB-1:0] r3_m;
    logic [2:0]    r3_sector;
    logic [HB-1:0] r3_frac;

    // Stage 4: secondary component product.
    logic           r4_valid;
    t_hsva          r4_d;
    logic [CB-1:0]  r4_c;
    logic [CB-1:0]  r4_m;
    logic [2:0]     r4_sector;
    logic [CB+HB:0] r4_xprod;

    // Stage 5: output register.
    logic     r5_valid;
    t_rgb_rsp r5_rsp;
    t_rgb_rsp n5_rsp;

    logic [2*CB+1:0] n3_t;
    logic [CB:0]     n3_q0;
    logic [CB+2:0]   n3_r0;
    logic [CB:0]     n3_q;
    logic [CB-1:0]   n3_c;
    logic [HB:0]     n4_w;
    logic [CB+HB:0]  n5_xsum;
    logic [CB-1:0]   n5_x;
    logic [CB-1:0]   n5_r;
    logic [CB-1:0]   n5_g;
    logic [CB-1:0]   n5_b;

    assign en5     = !r5_valid || !i_stall;
    assign en4     = !r4_valid || en5;
    assign en3     = !r3_valid || en4;
    assign en2     = !r2_valid || en3;
    assign en1     = !r1_valid || en2;
    assign o_stall = !en1;
    assign o_valid = r5_valid;
    assign o_rsp   = r5_rsp;

    always_comb begin
        n1_d.hue   = i_req.hue_in;
        n1_d.sat   = i_req.saturation_in;
        n1_d.val   = i_req.value_in;
        n1_d.alpha = i_req.alpha_in;
        unique case (i_req.kind)
            KIND_COMPLEMENT: begin
                if (i_req.hue_in >= HALF) begin
                    n1_d.hue = i_req.hue_in - HALF;
                end else begin
                    n1_d.hue = i_req.hue_in + HALF;
                end
            end
            KIND_TINT: begin
                n1_d.sat = (i_req.saturation_in > i_req.amount) ?
                           i_req.saturation_in - i_req.amount : '0;
            end
            KIND_SHADE: begin
                n1_d.val = (i_req.value_in > i_req.amount) ?
                           i_req.value_in - i_req.amount : '0;
            end
            default: begin
            end
        endcase
    end

    // Chroma is (2*v*s + CMAX) / (2*CMAX). The quotient by 2^(CB+1) is an
    // underestimate by at most two, fixed from the remainder.
    always_comb begin
        n3_t  = {1'b0, r2_vs, 1'b0} + {{(CB+2){1'b0}}, CMAX};
        n3_q0 = n3_t[2*CB+1:CB+1];
        n3_r0 = {2'b00, n3_t[CB:0]} + {1'b0, n3_q0, 1'b0};
        n3_q  = n3_q0 + {{CB{1'b0}}, (n3_r0 >= TWO_CMAX)}
                      + {{CB{1'b0}}, (n3_r0 >= FOUR_CMAX)};
        n3_c  = (n3_q > {1'b0, r2_d.val}) ? r2_d.val : n3_q[CB-1:0];
    end

    assign n4_w = r3_sector[0] ? (FULL - {1'b0, r3_frac}) : {1'b0, r3_frac};

    always_comb begin
        n5_xsum = r4_xprod + {{CB{1'b0}}, HALF};
        n5_x    = n5_xsum[CB+HB-1:HB];
        case (r4_sector)
            3'd0: begin
                n5_r = r4_c; n5_g = n5_x; n5_b = '0;
            end
            3'd1: begin
                n5_r = n5_x; n5_g = r4_c; n5_b = '0;
            end
            3'd2: begin
                n5_r = '0; n5_g = r4_c; n5_b = n5_x;
            end
            3'd3: begin
                n5_r = '0; n5_g = n5_x; n5_b = r4_c;
            end
            3'd4: begin
                n5_r = n5_x; n5_g = '0; n5_b = r4_c;
            end
            default: begin
                n5_r = r4_c; n5_g = '0; n5_b = n5_x;
            end
        endcase
        n5_rsp.hue_out        = r4_d.hue;
        n5_rsp.saturation_out = r4_d.sat;
        n5_rsp.value_out      = r4_d.val;
        n5_rsp.alpha_out      = r4_d.alpha;
        if (r4_d.hue[HB]) begin
            n5_rsp.red   = CMAX;
            n5_rsp.green = CMAX;
            n5_rsp.blue  = CMAX;
        end else begin
            n5_rsp.red   = n5_r + r4_m;
            n5_rsp.green = n5_g + r4_m;
            n5_rsp.blue  = n5_b + r4_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            if (en1) r1_valid <= i_valid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
            if (en4) r4_valid <= r3_valid;
            if (en5) r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_d <= n1_d;
        end
        if (en2) begin
            r2_d  <= r1_d;
            r2_vs <= r1_d.val * r1_d.sat;
            r2_h6 <= {3'b000, r1_d.hue[HB-1:0]} * (HB+3)'(6);
        end
        if (en3) begin
            r3_d      <= r2_d;
            r3_c      <= n3_c;
            r3_m      <= r2_d.val - n3_c;
            r3_sector <= r2_h6[HB+2:HB];
            r3_frac   <= r2_h6[HB-1:0];
        end
        if (en4) begin
            r4_d      <= r3_d;
            r4_c      <= r3_c;
            r4_m      <= r3_m;
            r4_sector <= r3_sector;
            r4_xprod  <= r3_c * n4_w;
        end
        if (en5) begin
            r5_rsp <= n5_rsp;
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import h2r_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_COUNT   = 1950;

    typedef struct packed {
        t_hsv_req req;
        logic     fixed;
        t_rgb_rsp rsp;
    } t_dir_row;

    localparam t_rgb_rsp NO_RSP = '0;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_stall = 1'b0;
    t_hsv_req i_req   = '0;
    logic     o_stall;
    logic     o_valid;
    t_rgb_rsp o_rsp;

    t_rgb_rsp pending_colors [$];
    t_dir_row directed_rows [25];
    int       failures     = 0;
    int       quiet_cycles = 0;
    bit       sender_idles = 1'b1;

    hsv_to_rgb_converter_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_hsv_req mk_req(input t_kind kind, input int unsigned hue,
                                        input int unsigned sat, input int unsigned val,
                                        input int unsigned alpha, input int unsigned amount);
        t_hsv_req r;
        r.kind          = kind;
        r.hue_in        = hue[HUE_BITS:0];
        r.saturation_in = sat[CHANNEL_BITS-1:0];
        r.value_in      = val[CHANNEL_BITS-1:0];
        r.alpha_in      = alpha[CHANNEL_BITS-1:0];
        r.amount        = amount[CHANNEL_BITS-1:0];
        return r;
    endfunction

    function automatic t_rgb_rsp mk_rsp(input int unsigned hue, input int unsigned sat,
                                        input int unsigned val, input int unsigned alpha,
                                        input int unsigned red, input int unsigned green,
                                        input int unsigned blue);
        t_rgb_rsp r;
        r.hue_out        = hue[HUE_BITS:0];
        r.saturation_out = sat[CHANNEL_BITS-1:0];
        r.value_out      = val[CHANNEL_BITS-1:0];
        r.alpha_out      = alpha[CHANNEL_BITS-1:0];
        r.red            = red[CHANNEL_BITS-1:0];
        r.green          = green[CHANNEL_BITS-1:0];
        r.blue           = blue[CHANNEL_BITS-1:0];
        return r;
    endfunction

    // Applies the requested edit to the HSV color, then converts it to RGB.
    function automatic t_rgb_rsp edit_and_convert(input t_hsv_req r);
        logic [HUE_BITS:0] hue;
        int unsigned       sat;
        int unsigned       val;
        int unsigned       chroma;
        int unsigned       offset;
        int unsigned       second;
        int unsigned       h6;
        int unsigned       sector;
        int unsigned       frac;
        int unsigned       full_turn;
        int unsigned       cmax_i;
        int unsigned       ch [3];
        full_turn = FULL;
        cmax_i    = CMAX;
        hue       = r.hue_in;
        sat       = r.saturation_in;
        val       = r.value_in;
        case (r.kind)
            KIND_COMPLEMENT: hue = (hue >= HALF) ? hue - HALF : hue + HALF;
            KIND_TINT:       sat = (sat > r.amount) ? sat - r.amount : 0;
            KIND_SHADE:      val = (val > r.amount) ? val - r.amount : 0;
            default: ;
        endcase
        if (hue >= FULL) begin
            ch = '{cmax_i, cmax_i, cmax_i};
        end else begin
            chroma = (2 * val * sat + cmax_i) / (2 * cmax_i);
            if (chroma > val) begin
                chroma = val;
            end
            offset = val - chroma;
            h6     = int'(hue) * 6;
            sector = h6 >> HUE_BITS;
            frac   = h6 & (full_turn - 1);
            if (sector % 2 == 1) begin
                second = (chroma * (full_turn - frac) + full_turn / 2) >> HUE_BITS;
            end else begin
                second = (chroma * frac + full_turn / 2) >> HUE_BITS;
            end
            case (sector)
                0:       ch = '{chroma, second, 0};
                1:       ch = '{second, chroma, 0};
                2:       ch = '{0, chroma, second};
                3:       ch = '{0, second, chroma};
                4:       ch = '{second, 0, chroma};
                default: ch = '{chroma, 0, second};
            endcase
            foreach (ch[i]) begin
                ch[i] = ch[i] + offset;
            end
        end
        return mk_rsp(hue, sat, val, r.alpha_in, ch[0], ch[1], ch[2]);
    endfunction

    function automatic int unsigned pick_channel();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return CMAX;
            default: return $urandom_range(0, CMAX);
        endcase
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    task automatic send_request(input t_hsv_req r, input t_rgb_rsp want);
        int gap;
        gap = sender_idles ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_colors.push_back(want);
    endtask

    initial begin : stimulus
        t_hsv_req r;
        directed_rows = '{
            '{mk_req(KIND_CONVERT, 0, 255, 255, 255, 0), 1'b1,
              mk_rsp(0, 255, 255, 255, 255, 0, 0)},
            '{mk_req(KIND_CONVERT, 65536, 255, 255, 0, 0), 1'b1,
              mk_rsp(65536, 255, 255, 0, 255, 255, 255)},
            '{mk_req(KIND_CONVERT, 131071, 0, 0, 128, 255), 1'b1,
              mk_rsp(131071, 0, 0, 128, 255, 255, 255)},
            '{mk_req(KIND_COMPLEMENT, 0, 255, 255, 85, 0), 1'b0, NO_RSP},
            '{mk_req(KIND_COMPLEMENT, 131071, 200, 50, 170, 0), 1'b1,
              mk_rsp(98303, 200, 50, 170, 255, 255, 255)},
            '{mk_req(KIND_COMPLEMENT, 65536, 255, 255, 255, 255), 1'b0, NO_RSP},
            '{mk_req(KIND_COMPLEMENT, 32767, 255, 128, 1, 0), 1'b0, NO_RSP},
            '{mk_req(KIND_COMPLEMENT, 32768, 128, 255, 254, 0), 1'b0, NO_RSP},
            '{mk_req(KIND_TINT, 1000, 100, 200, 255, 255), 1'b1,
              mk_rsp(1000, 0, 200, 255, 200, 200, 200)},
            '{mk_req(KIND_TINT, 30000, 255, 255, 0, 0), 1'b0, NO_RSP},
            '{mk_req(KIND_TINT, 50000, 255, 255, 0, 1), 1'b0, NO_RSP},
            '{mk_req(KIND_SHADE, 5000, 255, 100, 0, 255), 1'b1,
              mk_rsp(5000, 255, 0, 0, 0, 0, 0)},
            '{mk_req(KIND_SHADE, 60000, 255, 255, 77, 1), 1'b0, NO_RSP},
            '{mk_req(KIND_CONVERT, 40000, 255, 0, 0, 0), 1'b1,
              mk_rsp(40000, 255, 0, 0, 0, 0, 0)},
            '{mk_req(KIND_CONVERT, 20000, 0, 255, 0, 0), 1'b1,
              mk_rsp(20000, 0, 255, 0, 255, 255, 255)},
            '{mk_req(KIND_CONVERT, 10922, 255, 255, 255, 0), 1'b0, NO_RSP},
            '{mk_req(KIND_CONVERT, 10923, 255, 255, 255, 0), 1'b0, NO_RSP},
            '{mk_req(KIND_CONVERT, 21845, 255, 255, 255, 0), 1'b0, NO_RSP},
            '{mk_req(KIND_CONVERT, 21846, 255, 255, 255, 0), 1'b0, NO_RSP},
            '{mk_req(KIND_CONVERT, 43690, 255, 255, 255, 0), 1'b0, NO_RSP},
            '{mk_req(KIND_CONVERT, 43691, 255, 255, 255, 0), 1'b0, NO_RSP},
            '{mk_req(KIND_CONVERT, 54613, 255, 255, 255, 0), 1'b0, NO_RSP},
            '{mk_req(KIND_CONVERT, 54614, 255, 255, 255, 0), 1'b0, NO_RSP},
            '{mk_req(KIND_CONVERT, 65535, 255, 255, 255, 255), 1'b0, NO_RSP},
            '{mk_req(KIND_CONVERT, 0, 0, 0, 0, 0), 1'b1,
              mk_rsp(0, 0, 0, 0, 0, 0, 0)}
        };
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req,
                         directed_rows[i].fixed ? directed_rows[i].rsp
                                                : edit_and_convert(directed_rows[i].req));
        end
        for (int n = 0; n < RANDOM_COUNT; n++) begin
            if (n % 150 == 0) begin
                sender_idles = ($urandom_range(0, 2) != 0);
            end
            r = mk_req(t_kind'($urandom_range(0, 3)),
                       ($urandom_range(0, 9) == 0) ? $urandom_range(65536, 131071)
                                                   : $urandom_range(0, 65535),
                       pick_channel(), pick_channel(), pick_channel(), pick_channel());
            send_request(r, edit_and_convert(r));
        end
        i_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : receiver
        int       hold;
        int       seen;
        bit       stalls;
        t_rgb_rsp want;
        seen   = 0;
        stalls = 1'b1;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (seen % 150 == 0) begin
                stalls = ($urandom_range(0, 2) != 0);
            end
            hold = stalls ? $urandom_range(0, 3) : 0;
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            seen++;
            if (pending_colors.size() == 0) begin
                $error("result arrived with no request outstanding");
                failures++;
            end else begin
                want = pending_colors.pop_front();
                compare_field("hue_out", want.hue_out, o_rsp.hue_out);
                compare_field("saturation_out", want.saturation_out, o_rsp.saturation_out);
                compare_field("value_out", want.value_out, o_rsp.value_out);
                compare_field("alpha_out", want.alpha_out, o_rsp.alpha_out);
                compare_field("red", want.red, o_rsp.red);
                compare_field("green", want.green, o_rsp.green);
                compare_field("blue", want.blue, o_rsp.blue);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

### files.f
src/h2r_pkg.sv
src/hsv_to_rgb_converter_unit.sv
bench/tb_top.sv
